// ===== src/etcs_pkg.sv =====
package etcs_pkg;

  localparam logic [1:0] PEND_NONE     = 2'd0;
  localparam logic [1:0] PEND_ARMED    = 2'd1;
  localparam logic [1:0] PEND_DEFERRED = 2'd2;

  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef struct packed {
    logic        fired;
    logic [31:0] current_tick;
    logic [1:0]  pending;
  } etcs_result_t;

  typedef struct packed {
    logic fire;
    logic arm;
    logic defer;
  } etcs_eval_t;

  // Decides what an already decremented target does against tick c.
  function automatic etcs_eval_t etcs_evaluate(input logic [31:0] t, input logic [31:0] c);
    etcs_eval_t  r;
    logic [31:0] diff;
    r    = '0;
    diff = c - t;
    if (t[31:16] == c[31:16]) begin
      if (t <= c) begin
        r.fire = 1'b1;
      end else begin
        r.arm = 1'b1;
      end
    // Exactly half the range behind counts as reached only when the target is below the tick.
    end else if ((diff != 32'd0) && ((diff < HALF_RANGE) || ((diff == HALF_RANGE) && (t < c))))
    begin
      r.fire = 1'b1;
    end else begin
      r.defer = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/etcs_core.sv =====
module etcs_core
  import etcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         advance,
  input  logic         mode,
  input  logic [31:0]  target_tick,
  output etcs_result_t result
);

  logic [15:0] divisor_r;
  logic [15:0] prescale_r, prescale_nxt;
  logic [15:0] low_r, low_nxt;
  logic [15:0] epoch_r, epoch_nxt;
  logic [15:0] compare_r, compare_nxt;
  logic        armed_r, armed_nxt;
  logic        deferred_r, deferred_nxt;
  logic [31:0] def_target_r, def_target_nxt;

  logic [16:0] count_inc;
  logic [15:0] low_inc;
  logic [15:0] epoch_inc;
  logic [31:0] sched_t;
  etcs_eval_t  sched_ev;
  etcs_eval_t  wrap_ev;
  logic        fired;

  assign count_inc = {1'b0, prescale_r} + 17'd1;
  assign low_inc   = low_r + 16'd1;
  assign epoch_inc = epoch_r + 16'd1;
  assign sched_t   = target_tick - 32'd1;
  assign sched_ev  = etcs_evaluate(sched_t, {epoch_r, low_r});
  // After a wrap the new tick is the next epoch with a zero low half.
  assign wrap_ev   = etcs_evaluate(def_target_r, {epoch_inc, 16'h0000});

  always_comb begin
    prescale_nxt   = prescale_r;
    low_nxt        = low_r;
    epoch_nxt      = epoch_r;
    compare_nxt    = compare_r;
    armed_nxt      = armed_r;
    deferred_nxt   = deferred_r;
    def_target_nxt = def_target_r;
    fired          = 1'b0;
    if (mode) begin
      fired        = sched_ev.fire;
      armed_nxt    = sched_ev.arm;
      deferred_nxt = sched_ev.defer;
      if (sched_ev.arm) begin
        compare_nxt = sched_t[15:0];
      end
      if (sched_ev.defer) begin
        def_target_nxt = sched_t;
      end
    end else if (count_inc >= {1'b0, divisor_r}) begin
      prescale_nxt = '0;
      low_nxt      = low_inc;
      if (armed_r && (low_inc == compare_r)) begin
        fired        = 1'b1;
        armed_nxt    = 1'b0;
        deferred_nxt = 1'b0;
      end
      if (low_inc == 16'h0000) begin
        epoch_nxt = epoch_inc;
        // The deferred target is already decremented, so it is evaluated as it stands.
        if (deferred_nxt) begin
          fired        = fired | wrap_ev.fire;
          armed_nxt    = wrap_ev.arm;
          deferred_nxt = wrap_ev.defer;
          if (wrap_ev.arm) begin
            compare_nxt = def_target_r[15:0];
          end
        end
      end
    end else begin
      prescale_nxt = count_inc[15:0];
    end
  end

  always_comb begin
    result.fired        = fired;
    result.current_tick = {epoch_nxt, low_nxt};
    result.pending      = armed_nxt ? PEND_ARMED : (deferred_nxt ? PEND_DEFERRED : PEND_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r    <= 16'd1;
      prescale_r   <= '0;
      low_r        <= '0;
      epoch_r      <= '0;
      compare_r    <= '0;
      armed_r      <= 1'b0;
      deferred_r   <= 1'b0;
      def_target_r <= '0;
    end else begin
      if (cfg_we) begin
        divisor_r <= cfg_wdata;
      end
      if (advance) begin
        prescale_r   <= prescale_nxt;
        low_r        <= low_nxt;
        epoch_r      <= epoch_nxt;
        compare_r    <= compare_nxt;
        armed_r      <= armed_nxt;
        deferred_r   <= deferred_nxt;
        def_target_r <= def_target_nxt;
      end
    end
  end

endmodule

// ===== src/extended_timer_callback_scheduler.sv =====
// A 16-bit prescaled counter extended to 32 bits by an overflow-counted upper
// half, with one scheduled callback. Every word gives exactly one result word:
// fired, the 32-bit tick after the word, and the pending state. A word is
// registered on entry, worked out combinationally and registered on exit, so the
// block takes one word per clock while the result side is not stalled; a result
// word is offered from the output register after its input word leaves the input
// register. While a result waits to be taken the input register can still take
// one more word before in_stall rises.
// cfg_data sets the prescale divisor (reset 1, zero behaves as 1); the user must
// write it only while the block is idle, and the block itself does not enforce this.
module extended_timer_callback_scheduler
  import etcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_target_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fired,
  output logic [31:0] out_current_tick,
  output logic [1:0]  out_pending
);

  logic         in_valid_r;
  logic         in_mode_r;
  logic [31:0]  in_target_r;
  logic         out_valid_r;
  etcs_result_t out_r;
  etcs_result_t result;
  logic         advance;
  logic         in_take;

  // The stage moves on when it holds a word and the result register is free or being taken.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  etcs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_data),
    .advance    (advance),
    .mode       (in_mode_r),
    .target_tick(in_target_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r   <= in_mode;
      in_target_r <= in_target_tick;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_r.fired;
  assign out_current_tick = out_r.current_tick;
  assign out_pending      = out_r.pending;

endmodule

// ===== src/etcs_checker.sv =====
module etcs_checker
  import etcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic [31:0] in_target_tick,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_fired,
  input logic [31:0] out_current_tick,
  input logic [1:0]  out_pending
);

  // A stalled input word keeps its contents until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode) && $stable(in_target_tick))
    else $error("input word changed while stalled");

  // A held result word keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fired)
      && $stable(out_current_tick) && $stable(out_pending))
    else $error("result word changed while stalled");

  // With the result side empty the input side never stalls.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_pending_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pending == PEND_NONE) || (out_pending == PEND_ARMED)
      || (out_pending == PEND_DEFERRED))
    else $error("pending holds an unused code");

  // Firing always leaves nothing pending.
  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_pending == PEND_NONE)
    else $error("callback fired but still pending");

endmodule

bind extended_timer_callback_scheduler etcs_checker u_etcs_checker (.*);

// ===== sim/extended_timer_callback_scheduler_tb.sv =====
module extended_timer_callback_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etcs_pkg::*;

  localparam logic MODE_STEP     = 1'b0;
  localparam logic MODE_SCHEDULE = 1'b1;
  localparam int   QUIET_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [31:0] in_target_tick;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_fired;
  logic [31:0] out_current_tick;
  logic [1:0]  out_pending;

  // Predicted timer state, updated as each input word is accepted.
  logic [15:0] pred_divisor  = 16'd1;
  logic [15:0] pred_prescale = 16'd0;
  logic [15:0] pred_low      = 16'd0;
  logic [15:0] pred_epoch    = 16'd0;
  logic [15:0] pred_compare  = 16'd0;
  bit          pred_armed    = 1'b0;
  bit          pred_deferred = 1'b0;
  logic [31:0] pred_deferred_target = 32'd0;

  etcs_result_t due_results[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int burst_left     = 0;
  int stall_hold     = 0;
  int stall_level    = 0;
  bit gaps_on        = 1'b1;

  extended_timer_callback_scheduler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_target_tick   (in_target_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_current_tick (out_current_tick),
    .out_pending      (out_pending)
  );

  always #4 clk = ~clk;

  // Decides the fate of a target that has already had its tick of overhead taken off.
  function automatic bit resolve_callback(input logic [31:0] t);
    logic [31:0] now;
    logic [31:0] behind;
    now    = {pred_epoch, pred_low};
    behind = now - t;
    if (t[31:16] == pred_epoch) begin
      if (t <= now) begin
        pred_armed    = 1'b0;
        pred_deferred = 1'b0;
        return 1'b1;
      end
      pred_deferred = 1'b0;
      pred_armed    = 1'b1;
      pred_compare  = t[15:0];
      return 1'b0;
    end
    if ((t < now && behind <= HALF_RANGE) || (t > now && (t - now) > HALF_RANGE)) begin
      pred_armed    = 1'b0;
      pred_deferred = 1'b0;
      return 1'b1;
    end
    pred_deferred        = 1'b1;
    pred_armed           = 1'b0;
    pred_deferred_target = t;
    return 1'b0;
  endfunction

  task automatic predict_tick_word(input logic mode, input logic [31:0] tgt,
                                   output etcs_result_t res);
    bit          hit;
    logic [16:0] nxt;
    hit = 1'b0;
    if (mode == MODE_SCHEDULE) begin
      hit = resolve_callback(tgt - 32'd1);
    end else begin
      nxt = {1'b0, pred_prescale} + 17'd1;
      if (nxt >= {1'b0, pred_divisor}) begin
        pred_prescale = 16'd0;
        pred_low      = pred_low + 16'd1;
        if (pred_armed && (pred_low == pred_compare)) begin
          pred_armed    = 1'b0;
          pred_deferred = 1'b0;
          hit           = 1'b1;
        end
        if (pred_low == 16'd0) begin
          pred_epoch = pred_epoch + 16'd1;
          if (pred_deferred && resolve_callback(pred_deferred_target)) begin
            hit = 1'b1;
          end
        end
      end else begin
        pred_prescale = nxt[15:0];
      end
    end
    res.fired        = hit;
    res.current_tick = {pred_epoch, pred_low};
    res.pending      = pred_armed ? PEND_ARMED : (pred_deferred ? PEND_DEFERRED : PEND_NONE);
  endtask

  task automatic drive_word(input logic mode, input logic [31:0] tgt);
    etcs_result_t res;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_target_tick <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick_word(mode, tgt, res);
    due_results.push_back(res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [15:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pred_divisor = value;
  endtask

  task automatic test_directed_scheduling();
    logic [31:0] now;
    gaps_on     = 1'b1;
    stall_level = 2;
    drive_word(MODE_STEP, 32'hFFFF_FFFF);
    drive_word(MODE_STEP, 32'h0000_0000);
    drive_word(MODE_STEP, 32'h5A5A_A5A5);
    // A target of zero wraps round to the last tick, which lies just behind.
    drive_word(MODE_SCHEDULE, 32'h0000_0000);
    drive_word(MODE_SCHEDULE, 32'h0000_0001);
    drive_word(MODE_SCHEDULE, 32'hFFFF_FFFF);
    now = {pred_epoch, pred_low};
    drive_word(MODE_SCHEDULE, now + 32'd1);
    drive_word(MODE_SCHEDULE, now + 32'd4);
    repeat (3) drive_word(MODE_STEP, $urandom);
    now = {pred_epoch, pred_low};
    drive_word(MODE_SCHEDULE, now + 32'd10);
    // Each new schedule replaces the callback that was pending before it.
    drive_word(MODE_SCHEDULE, 32'h0005_0000);
    drive_word(MODE_SCHEDULE, 32'h0001_0000);
    now = {pred_epoch, pred_low};
    drive_word(MODE_SCHEDULE, now + 32'h8000_0001);
    drive_word(MODE_SCHEDULE, now + 32'h8000_0000);
    drive_word(MODE_SCHEDULE, now + 32'h8000_0002);
    drive_word(MODE_STEP, $urandom);
  endtask

  task automatic test_divisor_settings();
    stall_level = 1;
    write_divisor(16'd0);
    repeat (4) drive_word(MODE_STEP, $urandom);
    write_divisor(16'd3);
    repeat (7) drive_word(MODE_STEP, $urandom);
    write_divisor(16'd10);
    repeat (6) drive_word(MODE_STEP, $urandom);
    // The running prescale count is now above the new divisor.
    write_divisor(16'd2);
    repeat (3) drive_word(MODE_STEP, $urandom);
    write_divisor(16'hFFFF);
    drive_word(MODE_SCHEDULE, {pred_epoch, pred_low} + 32'd2);
    repeat (5) drive_word(MODE_STEP, $urandom);
    write_divisor(16'd1);
  endtask

  task automatic test_epoch_targets();
    logic [15:0] offs;
    gaps_on     = 1'b0;
    stall_level = 1;
    offs = 16'($urandom_range(1, 255));
    // A target in the next epoch stays deferred while the low half keeps counting.
    drive_word(MODE_SCHEDULE, {pred_epoch + 16'd1, offs} + 32'd1);
    repeat (4) drive_word(MODE_STEP, $urandom);
    offs = 16'($urandom);
    drive_word(MODE_SCHEDULE, {pred_epoch - 16'd1, offs} + 32'd1);
    drive_word(MODE_SCHEDULE, {pred_epoch + 16'd2, 16'h0000} + 32'd1);
    stall_level = 0;
    repeat (3) drive_word(MODE_STEP, $urandom);
    // A target in the current epoch replaces the deferred one and arms the compare.
    drive_word(MODE_SCHEDULE, {pred_epoch, pred_low} + 32'd3);
    repeat (4) drive_word(MODE_STEP, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [31:0] now;
    logic [31:0] tgt;
    logic [15:0] offs;
    logic [15:0] div;
    int          count;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          div = 16'd1;
        end
        1: begin
          div = 16'd2;
        end
        2: begin
          div = 16'd0;
        end
        3: begin
          div = 16'($urandom_range(3, 9));
        end
        4: begin
          div = 16'hFFFF;
        end
        default: begin
          div = 16'd1;
        end
      endcase
      write_divisor(div);
      count       = (div == 16'hFFFF) ? 20 : 65;
      stall_level = phase % 4;
      gaps_on     = (phase != 1);
      for (int n = 0; n < count; n++) begin
        if (phase == 3 && n == count / 2) begin
          drain_results();
        end
        if ($urandom_range(0, 99) < 60) begin
          drive_word(MODE_STEP, $urandom);
        end else begin
          now  = {pred_epoch, pred_low};
          offs = 16'($urandom);
          case ($urandom_range(0, 5))
            0, 1: begin
              tgt = now + $urandom_range(2, 24);
            end
            2: begin
              tgt = now - $urandom_range(0, 40) + 32'd1;
            end
            3: begin
              tgt = $urandom;
            end
            4: begin
              tgt = now + 32'h8000_0000 + $urandom_range(0, 2);
            end
            default: begin
              tgt = {pred_epoch + 16'd1, offs};
            end
          endcase
          drive_word(MODE_SCHEDULE, tgt);
        end
      end
    end
  endtask

  // The receiver holds each stall decision for a random number of cycles.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_hold <= $urandom_range(0, 7);
      out_stall  <= (stall_level != 0) && ($urandom_range(0, 3) < stall_level);
    end
  end

  always @(posedge clk) begin : check_results
    etcs_result_t want;
    etcs_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.fired        = out_fired;
      got.current_tick = out_current_tick;
      got.pending      = out_pending;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word: fired=%0d tick=%h pending=%0d",
                   got.fired, got.current_tick, got.pending);
        end
      end else begin
        want = due_results.pop_front();
        if (got.fired !== want.fired || got.current_tick !== want.current_tick ||
            got.pending !== want.pending) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"result mismatch: expected fired=%0d tick=%h pending=%0d, ",
                      "got fired=%0d tick=%h pending=%0d"},
                     want.fired, want.current_tick, want.pending,
                     got.fired, got.current_tick, got.pending);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("extended_timer_callback_scheduler_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= 16'd0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_STEP;
    in_target_tick <= 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_scheduling();
    test_divisor_settings();
    test_epoch_targets();
    test_random_traffic();
    drain_results();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("extended_timer_callback_scheduler_tb: PASS");
    end else begin
      $display("extended_timer_callback_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/etcs_pkg.sv
src/etcs_core.sv
src/extended_timer_callback_scheduler.sv
src/etcs_checker.sv
sim/extended_timer_callback_scheduler_tb.sv
